[rtl/brb_pkg.sv]
// brb_pkg: shared types and constants for the byte ring buffer
// no dependencies; imported by every module of the block
package brb_pkg;

    localparam int DEF_CAPACITY = 255;
    localparam int DEF_MAX_PEEK = 64;
    localparam int DATA_W       = 8;
    localparam int CNT_W        = 8;

    typedef enum logic [1:0] {
        CMD_PUSH_BEGIN = 2'd0,
        CMD_PUSH_BYTE  = 2'd1,
        CMD_POP        = 2'd2,
        CMD_PEEK       = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NO_ROOM  = 2'd1,
        STS_TOO_LONG = 2'd2,
        STS_NO_PUSH  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_PEEK
    } t_state;

endpackage

[rtl/brb_store.sv]
// brb_store: byte storage of the ring, one write and one registered read port
// depends on brb_pkg
module brb_store #(
    parameter int SLOTS = brb_pkg::DEF_CAPACITY + 1,
    parameter int AW    = $clog2(SLOTS)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [brb_pkg::DATA_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [brb_pkg::DATA_W-1:0] o_rdata
);
    import brb_pkg::*;

    logic [DATA_W-1:0] mem [0:SLOTS-1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/brb_ctrl.sv]
// brb_ctrl: pointer registers, command decode and peek sequencer
// depends on brb_pkg; drives the read and write ports of brb_store
module brb_ctrl #(
    parameter int CAPACITY = brb_pkg::DEF_CAPACITY,
    parameter int MAX_PEEK = brb_pkg::DEF_MAX_PEEK,
    parameter int AW       = $clog2(CAPACITY + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_cmd,
    input  logic [brb_pkg::CNT_W-1:0]  i_count,
    input  logic [brb_pkg::DATA_W-1:0] i_data,
    output logic                       o_strobe,
    output logic [1:0]                 o_status,
    output logic [brb_pkg::DATA_W-1:0] o_byte_out,
    output logic                       o_last,
    output logic [brb_pkg::CNT_W-1:0]  o_used_bytes,
    output logic [brb_pkg::CNT_W-1:0]  o_free_bytes,
    output logic                       o_we,
    output logic [AW-1:0]              o_waddr,
    output logic [brb_pkg::DATA_W-1:0] o_wdata,
    output logic                       o_re,
    output logic [AW-1:0]              o_raddr,
    input  logic [brb_pkg::DATA_W-1:0] i_rdata
);
    import brb_pkg::*;

    localparam int SLOTS = CAPACITY + 1;
    localparam int CMP_W = (AW > CNT_W) ? AW : CNT_W;
    localparam int SUM_W = CMP_W + 1;
    localparam int LW    = (MAX_PEEK > 1) ? $clog2(MAX_PEEK) : 1;
    localparam logic [AW-1:0]   CAP_A   = AW'(CAPACITY);
    localparam logic [AW:0]     SLOTS_E = (AW + 1)'(SLOTS);
    localparam logic [SUM_W-1:0] SLOTS_S = SUM_W'(SLOTS);
    localparam logic [CNT_W-1:0] MAXP_C = CNT_W'(MAX_PEEK);

    t_state r_state, n_state;

    logic [AW-1:0]     r_read_ptr,  n_read_ptr;
    logic [AW-1:0]     r_write_ptr, n_write_ptr;
    logic [AW-1:0]     r_pend_ptr,  n_pend_ptr;
    logic [CNT_W-1:0]  r_remain,    n_remain;
    logic              r_open,      n_open;
    logic [AW-1:0]     r_rd_ptr,    n_rd_ptr;
    logic [LW-1:0]     r_left,      n_left;
    logic              r_strobe,    n_strobe;
    t_status           r_status,    n_status;
    logic              r_last,      n_last;
    logic              r_sel,       n_sel;

    logic              accept;
    t_cmd              cmd;
    logic [AW:0]       used_e;
    logic [AW-1:0]     used;
    logic [AW-1:0]     free;
    logic [CMP_W-1:0]  used_x, free_x, count_x;
    logic [SUM_W-1:0]  pop_sum;
    logic [AW-1:0]     pend_inc, rd_inc, read_inc;
    logic [CNT_W-1:0]  remain_dec;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        q = (p == CAP_A) ? '0 : p + AW'(1);
        return q;
    endfunction

    assign busy   = (r_state == S_PEEK);
    assign accept = start && !busy;
    assign cmd    = t_cmd'(i_cmd);

    // committed occupancy, pointers wrap modulo the slot count
    assign used_e = {1'b0, r_write_ptr} - {1'b0, r_read_ptr}
                  + ((r_write_ptr < r_read_ptr) ? SLOTS_E : '0);
    assign used    = used_e[AW-1:0];
    assign free    = CAP_A - used;
    assign used_x  = CMP_W'(used);
    assign free_x  = CMP_W'(free);
    assign count_x = CMP_W'(i_count);

    assign pop_sum    = SUM_W'(r_read_ptr) + SUM_W'(i_count);
    assign pend_inc   = ptr_inc(r_pend_ptr);
    assign rd_inc     = ptr_inc(r_rd_ptr);
    assign read_inc   = ptr_inc(r_read_ptr);
    assign remain_dec = r_remain - CNT_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && cmd == CMD_PEEK && i_count <= MAXP_C
                        && count_x <= used_x && i_count > CNT_W'(1)) begin
                    n_state = S_PEEK;
                end
            end
            S_PEEK: begin
                if (r_left == LW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory port control
    always_comb begin
        n_read_ptr  = r_read_ptr;
        n_write_ptr = r_write_ptr;
        n_pend_ptr  = r_pend_ptr;
        n_remain    = r_remain;
        n_open      = r_open;
        n_rd_ptr    = r_rd_ptr;
        n_left      = r_left;
        n_strobe    = 1'b0;
        n_status    = STS_OK;
        n_last      = 1'b1;
        n_sel       = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_pend_ptr;
        o_wdata     = i_data;
        o_re        = 1'b0;
        o_raddr     = r_read_ptr;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    case (cmd)
                        CMD_PUSH_BEGIN: begin
                            if (free_x < count_x) begin
                                n_status = STS_NO_ROOM;
                            end else begin
                                n_pend_ptr = r_write_ptr;
                                n_remain   = i_count;
                                n_open     = (i_count != '0);
                            end
                        end
                        CMD_PUSH_BYTE: begin
                            if (!r_open) begin
                                n_status = STS_NO_PUSH;
                            end else begin
                                o_we       = 1'b1;
                                n_pend_ptr = pend_inc;
                                n_remain   = remain_dec;
                                // last byte of the push commits it
                                if (remain_dec == '0) begin
                                    n_write_ptr = pend_inc;
                                    n_open      = 1'b0;
                                end
                            end
                        end
                        CMD_POP: begin
                            if (used_x < count_x) begin
                                n_status = STS_NO_ROOM;
                            end else if (pop_sum >= SLOTS_S) begin
                                n_read_ptr = AW'(pop_sum - SLOTS_S);
                            end else begin
                                n_read_ptr = AW'(pop_sum);
                            end
                        end
                        CMD_PEEK: begin
                            if (i_count > MAXP_C) begin
                                n_status = STS_TOO_LONG;
                            end else if (used_x < count_x) begin
                                n_status = STS_NO_ROOM;
                            end else if (i_count != '0) begin
                                o_re     = 1'b1;
                                n_sel    = 1'b1;
                                n_last   = (i_count == CNT_W'(1));
                                n_rd_ptr = read_inc;
                                n_left   = LW'(i_count - CNT_W'(1));
                            end
                        end
                        default: n_status = STS_OK;
                    endcase
                end
            end
            S_PEEK: begin
                o_re     = 1'b1;
                o_raddr  = r_rd_ptr;
                n_strobe = 1'b1;
                n_sel    = 1'b1;
                n_last   = (r_left == LW'(1));
                n_rd_ptr = rd_inc;
                n_left   = r_left - LW'(1);
            end
            default: n_strobe = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_read_ptr  <= '0;
            r_write_ptr <= '0;
            r_pend_ptr  <= '0;
            r_remain    <= '0;
            r_open      <= 1'b0;
            r_left      <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_read_ptr  <= n_read_ptr;
            r_write_ptr <= n_write_ptr;
            r_pend_ptr  <= n_pend_ptr;
            r_remain    <= n_remain;
            r_open      <= n_open;
            r_left      <= n_left;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_status <= n_status;
        r_last   <= n_last;
        r_sel    <= n_sel;
    end

    // pointers already hold the post-request state while the strobe is up
    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_last       = r_last;
    assign o_byte_out   = r_sel ? i_rdata : '0;
    assign o_used_bytes = used_x[CNT_W-1:0];
    assign o_free_bytes = free_x[CNT_W-1:0];

endmodule

[rtl/byte_ring_buffer.sv]
// byte_ring_buffer: top level of the byte ring buffer
// depends on brb_pkg, brb_store and brb_ctrl
//
//   channel   handshake            ports
//   request   start / busy         i_cmd, i_count, i_data
//   result    o_strobe (1 cycle)   o_status, o_byte_out, o_last,
//                                  o_used_bytes, o_free_bytes
//
// a request is taken when start is high and busy low; its first result
// shows in the next cycle. push_begin, push_byte and pop give one result and
// leave busy low, so one request per cycle. a peek of n > 0 bytes gives n
// results, one per cycle from the single storage read port, and holds busy
// as its later reads go out. reset is synchronous and needs no clearing pass.
// the receiver cannot stall: each result is valid for exactly one cycle.
module byte_ring_buffer #(
    parameter int CAPACITY = brb_pkg::DEF_CAPACITY,
    parameter int MAX_PEEK = brb_pkg::DEF_MAX_PEEK
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_cmd,
    input  logic [brb_pkg::CNT_W-1:0]  i_count,
    input  logic [brb_pkg::DATA_W-1:0] i_data,
    output logic                       o_strobe,
    output logic [1:0]                 o_status,
    output logic [brb_pkg::DATA_W-1:0] o_byte_out,
    output logic                       o_last,
    output logic [brb_pkg::CNT_W-1:0]  o_used_bytes,
    output logic [brb_pkg::CNT_W-1:0]  o_free_bytes
);
    import brb_pkg::*;

    localparam int SLOTS = CAPACITY + 1;
    localparam int AW    = $clog2(SLOTS);

    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [DATA_W-1:0] wdata, rdata;

    brb_ctrl #(
        .CAPACITY (CAPACITY),
        .MAX_PEEK (MAX_PEEK),
        .AW       (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_count      (i_count),
        .i_data       (i_data),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_byte_out   (o_byte_out),
        .o_last       (o_last),
        .o_used_bytes (o_used_bytes),
        .o_free_bytes (o_free_bytes),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata)
    );

    brb_store #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking testbench for byte_ring_buffer (push, pop and peek requests)
// depends on brb_pkg and the byte_ring_buffer rtl; a behavioral ring model predicts every result
module tb_top;
    import brb_pkg::*;

    localparam int CAPACITY   = DEF_CAPACITY;
    localparam int MAX_PEEK   = DEF_MAX_PEEK;
    localparam int SLOTS      = CAPACITY + 1;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = MAX_PEEK + 8;

    typedef struct {
        t_status     status;
        logic [7:0]  byte_out;
        logic        last;
        logic [7:0]  used_bytes;
        logic [7:0]  free_bytes;
    } t_ring_result;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic [1:0]  i_cmd   = '0;
    logic [7:0]  i_count = '0;
    logic [7:0]  i_data  = '0;
    logic        busy;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [7:0]  o_byte_out;
    logic        o_last;
    logic [7:0]  o_used_bytes;
    logic [7:0]  o_free_bytes;

    // model of the ring: storage, committed pointers and the open push
    logic [7:0]  ring_mem [SLOTS];
    int          head_ptr;
    int          tail_ptr;
    int          pend_ptr;
    logic [7:0]  bytes_left;
    logic        push_open;

    t_ring_result awaited_results [$];

    int  requests_sent;
    int  results_checked;
    int  mismatches;
    int  cmd_seen [4];
    int  idle_cycles;
    bit  no_gaps;

    byte_ring_buffer #(
        .CAPACITY (CAPACITY),
        .MAX_PEEK (MAX_PEEK)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_count      (i_count),
        .i_data       (i_data),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_byte_out   (o_byte_out),
        .o_last       (o_last),
        .o_used_bytes (o_used_bytes),
        .o_free_bytes (o_free_bytes)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int ring_used();
        return (tail_ptr + SLOTS - head_ptr) % SLOTS;
    endfunction

    function automatic void queue_result(t_status status, logic [7:0] value, logic last);
        t_ring_result r;
        r.status     = status;
        r.byte_out   = value;
        r.last       = last;
        r.used_bytes = 8'(ring_used());
        r.free_bytes = 8'(CAPACITY - ring_used());
        awaited_results.push_back(r);
    endfunction

    // advances the ring model by one request and queues what it must produce
    function automatic void apply_to_ring(t_cmd cmd, logic [7:0] count, logic [7:0] data);
        int used;
        used = ring_used();
        case (cmd)
            CMD_PUSH_BEGIN: begin
                if (CAPACITY - used < count) begin
                    queue_result(STS_NO_ROOM, 8'h00, 1'b1);
                end else begin
                    pend_ptr   = tail_ptr;
                    bytes_left = count;
                    push_open  = (count != 0);
                    queue_result(STS_OK, 8'h00, 1'b1);
                end
            end
            CMD_PUSH_BYTE: begin
                if (!push_open) begin
                    queue_result(STS_NO_PUSH, 8'h00, 1'b1);
                end else begin
                    ring_mem[pend_ptr] = data;
                    pend_ptr   = (pend_ptr + 1) % SLOTS;
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 0) begin
                        tail_ptr  = pend_ptr;
                        push_open = 1'b0;
                    end
                    queue_result(STS_OK, 8'h00, 1'b1);
                end
            end
            CMD_POP: begin
                if (used < count) begin
                    queue_result(STS_NO_ROOM, 8'h00, 1'b1);
                end else begin
                    head_ptr = (head_ptr + count) % SLOTS;
                    queue_result(STS_OK, 8'h00, 1'b1);
                end
            end
            default: begin
                if (count > MAX_PEEK) begin
                    queue_result(STS_TOO_LONG, 8'h00, 1'b1);
                end else if (used < count) begin
                    queue_result(STS_NO_ROOM, 8'h00, 1'b1);
                end else if (count == 0) begin
                    queue_result(STS_OK, 8'h00, 1'b1);
                end else begin
                    for (int i = 0; i < count; i++) begin
                        queue_result(STS_OK, ring_mem[(head_ptr + i) % SLOTS], i == count - 1);
                    end
                end
            end
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_request(t_cmd cmd, logic [7:0] count, logic [7:0] data);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_count <= count;
        i_data  <= data;
        do @(posedge i_clk); while (busy);
        apply_to_ring(cmd, count, data);
        requests_sent++;
        cmd_seen[cmd]++;
    endtask

    // sender holds off until every queued result has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
        end
    endtask

    // each strobed result is compared with the oldest one awaited
    always @(posedge i_clk) begin
        t_ring_result exp_r;
        if (i_rst_n && o_strobe) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got status %0d byte %0d",
                         $time, o_status, o_byte_out);
            end else begin
                exp_r = awaited_results.pop_front();
                check_field("status", exp_r.status, o_status);
                check_field("byte_out", exp_r.byte_out, o_byte_out);
                check_field("last", exp_r.last, o_last);
                check_field("used_bytes", exp_r.used_bytes, o_used_bytes);
                check_field("free_bytes", exp_r.free_bytes, o_free_bytes);
                results_checked++;
            end
        end
    end

    // a stray strobe with nothing awaited is no progress
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || (o_strobe && awaited_results.size() != 0)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic test_corner_cases();
        no_gaps = 1'b0;
        send_request(CMD_PUSH_BYTE, rand_byte(), 8'hFF);   // byte with no push open
        send_request(CMD_POP, 8'd0, rand_byte());
        send_request(CMD_POP, 8'd1, rand_byte());           // pop from empty
        send_request(CMD_PEEK, 8'd0, rand_byte());
        send_request(CMD_PEEK, 8'd1, rand_byte());          // peek past stored data
        send_request(CMD_PEEK, 8'(MAX_PEEK + 1), rand_byte());
        send_request(CMD_PEEK, 8'd255, 8'h00);
        send_request(CMD_PUSH_BEGIN, 8'd0, rand_byte());    // empty push opens nothing
        send_request(CMD_PUSH_BYTE, rand_byte(), 8'h00);
        send_request(CMD_PUSH_BEGIN, 8'd255, rand_byte());  // full-size push
        send_request(CMD_PUSH_BEGIN, 8'd3, rand_byte());    // abandons the open push
        send_request(CMD_PUSH_BYTE, 8'd0, 8'h00);
        send_request(CMD_PUSH_BYTE, 8'd255, 8'hFF);
        send_request(CMD_PUSH_BYTE, rand_byte(), 8'hA5);
        send_request(CMD_PUSH_BEGIN, 8'd2, rand_byte());
        send_request(CMD_PUSH_BEGIN, 8'd254, rand_byte());  // rejected, old push stays open
        send_request(CMD_PUSH_BYTE, rand_byte(), 8'h5A);
        send_request(CMD_PUSH_BYTE, rand_byte(), 8'hC3);
        send_request(CMD_PEEK, 8'd5, rand_byte());
        send_request(CMD_POP, 8'd6, rand_byte());
        send_request(CMD_POP, 8'd2, rand_byte());
        send_request(CMD_PEEK, 8'd3, rand_byte());
        send_request(CMD_PEEK, 8'd4, rand_byte());
        send_request(CMD_POP, 8'd3, rand_byte());
    endtask

    task automatic test_full_buffer();
        int room;
        no_gaps = 1'b1;
        send_request(CMD_POP, 8'(ring_used()), rand_byte());
        room = CAPACITY - ring_used();
        send_request(CMD_PUSH_BEGIN, 8'(room), rand_byte());
        no_gaps = 1'b0;
        for (int k = 0; k < room; k++) begin
            if (k == room / 2) no_gaps = 1'b1;
            send_request(CMD_PUSH_BYTE, rand_byte(), rand_byte());
        end
        no_gaps = 1'b0;
        send_request(CMD_PEEK, 8'(MAX_PEEK), rand_byte());
        send_request(CMD_PUSH_BEGIN, 8'd1, rand_byte());    // no room left
        send_request(CMD_PUSH_BYTE, rand_byte(), rand_byte());
        send_request(CMD_PEEK, 8'(MAX_PEEK + 1), rand_byte());
        send_request(CMD_POP, 8'd255, rand_byte());
    endtask

    task automatic test_random_traffic(int n_requests);
        int target;
        int sel;
        int n;
        int cut;
        int used;
        int room;
        target = requests_sent + n_requests;
        while (requests_sent < target) begin
            used    = ring_used();
            room    = CAPACITY - used;
            no_gaps = ($urandom_range(0, 4) == 0);
            sel     = $urandom_range(0, 99);
            if (sel < 40) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, room)
                                                : $urandom_range(0, room < 16 ? room : 16);
                // now and then the push is cut short and later abandoned
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : n;
                send_request(CMD_PUSH_BEGIN, 8'(n), rand_byte());
                for (int k = 0; k < cut; k++) begin
                    send_request(CMD_PUSH_BYTE, rand_byte(), rand_byte());
                end
            end else if (sel < 55) begin
                send_request(CMD_POP, 8'($urandom_range(0, used)), rand_byte());
            end else if (sel < 75) begin
                n = (used == 0) ? 0 : $urandom_range(1, used < MAX_PEEK ? used : MAX_PEEK);
                send_request(CMD_PEEK, 8'(n), rand_byte());
            end else if (sel < 88) begin
                case ($urandom_range(0, 3))
                    0: send_request(CMD_POP, (used < 255) ? 8'($urandom_range(used + 1, 255))
                                                          : rand_byte(), rand_byte());
                    1: send_request(CMD_PEEK, 8'($urandom_range(MAX_PEEK + 1, 255)), rand_byte());
                    2: send_request(CMD_PEEK, (used < MAX_PEEK)
                                              ? 8'($urandom_range(used + 1, MAX_PEEK))
                                              : 8'(MAX_PEEK + 1), rand_byte());
                    default: begin
                        if (room < 255) begin
                            send_request(CMD_PUSH_BEGIN, 8'($urandom_range(room + 1, 255)),
                                         rand_byte());
                        end else begin
                            send_request(CMD_PUSH_BYTE, rand_byte(), rand_byte());
                        end
                    end
                endcase
            end else begin
                send_request(t_cmd'($urandom_range(0, 3)), rand_byte(), rand_byte());
            end
        end
    endtask

    initial begin
        head_ptr        = 0;
        tail_ptr        = 0;
        pend_ptr        = 0;
        bytes_left      = '0;
        push_open       = 1'b0;
        requests_sent   = 0;
        results_checked = 0;
        mismatches      = 0;
        idle_cycles     = 0;
        no_gaps         = 1'b0;
        foreach (cmd_seen[i]) cmd_seen[i] = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_cases();
        drain_results();
        test_full_buffer();
        drain_results();
        test_random_traffic(160);
        drain_results();
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("covered %0d requests: %0d push_begin, %0d push_byte, %0d pop, %0d peek",
                 requests_sent, cmd_seen[CMD_PUSH_BEGIN], cmd_seen[CMD_PUSH_BYTE],
                 cmd_seen[CMD_POP], cmd_seen[CMD_PEEK]);
        $display("%0d results compared, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/brb_pkg.sv
rtl/brb_store.sv
rtl/brb_ctrl.sv
rtl/byte_ring_buffer.sv
verif/tb_top.sv
